/* rtl/gpvf_pkg.sv */
`timescale 1ns / 1ps

package gpvf_pkg;

  // Q16.32 values, Q1.30 coefficients
  localparam int VarW      = 48;
  localparam int CoefW     = 32;
  localparam int FracBits  = 30;
  localparam int CoefRegs  = 3;

  localparam int ArchLagsDef  = 3;
  localparam int GarchLagsDef = 3;

  // 48-bit operand split for the partial multipliers
  localparam int LoW     = 32;
  localparam int HiW     = VarW - LoW;
  localparam int LoProdW = LoW + 1 + CoefW;
  localparam int HiProdW = HiW + 1 + CoefW;

  // |product| <= 2^79, sum of six products plus omega stays below 2^83
  localparam int ProdW = VarW + CoefW + 1;
  localparam int AccW  = ProdW + 3;

  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (FracBits - 1);
  localparam logic [VarW-1:0]        VarMax    = '1;

  // APB: 64-bit data, registers on 8-byte boundaries
  localparam int DataW   = 64;
  localparam int RegIdxW = 3;
  localparam int AddrW   = RegIdxW + 3;

  typedef enum logic [RegIdxW-1:0] {
    RegOmega   = 3'd0,
    RegInitVar = 3'd1,
    RegArch1   = 3'd2,
    RegArch2   = 3'd3,
    RegArch3   = 3'd4,
    RegGarch1  = 3'd5,
    RegGarch2  = 3'd6,
    RegGarch3  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [VarW-1:0]                  omega;
    logic [VarW-1:0]                  initial_variance;
    logic [CoefRegs-1:0][CoefW-1:0]   arch_coef;
    logic [CoefRegs-1:0][CoefW-1:0]   garch_coef;
  } cfg_t;

  typedef struct packed {
    logic [VarW-1:0] residual_sq;
    logic            last_in_series;
  } in_item_t;

  typedef struct packed {
    logic [VarW-1:0] variance;
    logic            saturated;
    logic            last_out;
  } out_item_t;

endpackage

/* rtl/gpvf_regs.sv */
`timescale 1ns / 1ps

module gpvf_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gpvf_pkg::AddrW-1:0]   paddr,
  input  logic [gpvf_pkg::DataW-1:0]   pwdata,
  output logic [gpvf_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output gpvf_pkg::cfg_t               cfg
);

  gpvf_pkg::cfg_t     cfg_r;
  gpvf_pkg::cfg_t     cfg_nxt;
  gpvf_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = gpvf_pkg::reg_idx_t'(paddr[gpvf_pkg::AddrW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        gpvf_pkg::RegOmega:   cfg_nxt.omega            = pwdata[gpvf_pkg::VarW-1:0];
        gpvf_pkg::RegInitVar: cfg_nxt.initial_variance = pwdata[gpvf_pkg::VarW-1:0];
        gpvf_pkg::RegArch1:   cfg_nxt.arch_coef[0]     = pwdata[gpvf_pkg::CoefW-1:0];
        gpvf_pkg::RegArch2:   cfg_nxt.arch_coef[1]     = pwdata[gpvf_pkg::CoefW-1:0];
        gpvf_pkg::RegArch3:   cfg_nxt.arch_coef[2]     = pwdata[gpvf_pkg::CoefW-1:0];
        gpvf_pkg::RegGarch1:  cfg_nxt.garch_coef[0]    = pwdata[gpvf_pkg::CoefW-1:0];
        gpvf_pkg::RegGarch2:  cfg_nxt.garch_coef[1]    = pwdata[gpvf_pkg::CoefW-1:0];
        gpvf_pkg::RegGarch3:  cfg_nxt.garch_coef[2]    = pwdata[gpvf_pkg::CoefW-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gpvf_pkg::RegOmega:   prdata = gpvf_pkg::DataW'(cfg_r.omega);
      gpvf_pkg::RegInitVar: prdata = gpvf_pkg::DataW'(cfg_r.initial_variance);
      gpvf_pkg::RegArch1:   prdata = gpvf_pkg::DataW'(cfg_r.arch_coef[0]);
      gpvf_pkg::RegArch2:   prdata = gpvf_pkg::DataW'(cfg_r.arch_coef[1]);
      gpvf_pkg::RegArch3:   prdata = gpvf_pkg::DataW'(cfg_r.arch_coef[2]);
      gpvf_pkg::RegGarch1:  prdata = gpvf_pkg::DataW'(cfg_r.garch_coef[0]);
      gpvf_pkg::RegGarch2:  prdata = gpvf_pkg::DataW'(cfg_r.garch_coef[1]);
      gpvf_pkg::RegGarch3:  prdata = gpvf_pkg::DataW'(cfg_r.garch_coef[2]);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/garch_pq_variance_filter_unit.sv */
`timescale 1ns / 1ps
// A result passes the lag product registers, then the output register, and waits
// in the product stage while the output side stalls. The variance feedback loop
// keeps the next item out until the pending one has been summed, rounded and clipped.
// Reset (synchronous, rst_n low) clears the registers to zero, clears the
// history, marks the next sample as the start of a series and empties both stages.
module garch_pq_variance_filter_unit #(
  parameter int ARCH_LAGS  = gpvf_pkg::ArchLagsDef,
  parameter int GARCH_LAGS = gpvf_pkg::GarchLagsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gpvf_pkg::in_item_t           in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output gpvf_pkg::out_item_t          out_data,
  // configuration (APB)
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gpvf_pkg::AddrW-1:0]   paddr,
  input  logic [gpvf_pkg::DataW-1:0]   pwdata,
  output logic [gpvf_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  // Lags past the coefficient registers carry no weight, so no history for them.
  localparam int NA = (ARCH_LAGS  < gpvf_pkg::CoefRegs) ? ARCH_LAGS  : gpvf_pkg::CoefRegs;
  localparam int NG = (GARCH_LAGS < gpvf_pkg::CoefRegs) ? GARCH_LAGS : gpvf_pkg::CoefRegs;

  gpvf_pkg::cfg_t cfg;

  gpvf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Exact 48u x 32s product from a 32-bit and a 16-bit partial multiplier.
  function automatic logic signed [gpvf_pkg::ProdW-1:0] lag_product(
    input logic [gpvf_pkg::VarW-1:0]         x,
    input logic signed [gpvf_pkg::CoefW-1:0] c
  );
    logic signed [gpvf_pkg::LoProdW-1:0] p_lo;
    logic signed [gpvf_pkg::HiProdW-1:0] p_hi;
    p_lo = $signed({1'b0, x[gpvf_pkg::LoW-1:0]}) * c;
    p_hi = $signed({1'b0, x[gpvf_pkg::VarW-1:gpvf_pkg::LoW]}) * c;
    return (gpvf_pkg::ProdW'(p_hi) <<< gpvf_pkg::LoW) + gpvf_pkg::ProdW'(p_lo);
  endfunction

  // History of the current series: index 0 is one step back.
  logic [gpvf_pkg::VarW-1:0] res_hist_r [NA];
  logic [gpvf_pkg::VarW-1:0] res_hist_nxt [NA];
  logic [gpvf_pkg::VarW-1:0] var_hist_r [NG];
  logic [gpvf_pkg::VarW-1:0] var_hist_nxt [NG];
  logic                      start_r;
  logic                      start_nxt;

  // Product stage: filled on the input transfer, summed when the output register can take the result.
  logic signed [gpvf_pkg::ProdW-1:0] arch_prod_r [NA];
  logic signed [gpvf_pkg::ProdW-1:0] garch_prod_r [NG];
  logic [gpvf_pkg::VarW-1:0]         resid_r;
  logic                              last_r;
  logic                              pend_r;
  logic                              pend_nxt;

  // Output register
  gpvf_pkg::out_item_t out_data_r;
  logic                out_valid_r;
  logic                out_valid_nxt;

  logic                              in_fire;
  logic                              sum_fire;
  logic signed [gpvf_pkg::AccW-1:0]  acc;
  logic [gpvf_pkg::VarW-1:0]         var_val;
  logic                              sat_val;

  // The history only moves when the sum stage finishes, so the next item is
  // taken once the pending one has left the product stage.
  assign in_ready  = !pend_r;
  assign in_fire   = in_valid && in_ready;
  assign sum_fire  = pend_r && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sum, round half up to Q16.32, clip to 0 .. 2^48-1; a series start takes the initial variance.
  always_comb begin
    acc = gpvf_pkg::AccW'({cfg.omega, {gpvf_pkg::FracBits{1'b0}}});
    for (int k = 0; k < NA; k++) begin
      acc = acc + gpvf_pkg::AccW'(arch_prod_r[k]);
    end
    for (int k = 0; k < NG; k++) begin
      acc = acc + gpvf_pkg::AccW'(garch_prod_r[k]);
    end
    acc = acc + gpvf_pkg::RoundHalf;

    if (start_r) begin
      var_val = cfg.initial_variance;
      sat_val = 1'b0;
    end else if (acc[gpvf_pkg::AccW-1]) begin
      var_val = '0;
      sat_val = 1'b1;
    end else if (|acc[gpvf_pkg::AccW-2:gpvf_pkg::VarW+gpvf_pkg::FracBits]) begin
      var_val = gpvf_pkg::VarMax;
      sat_val = 1'b1;
    end else begin
      var_val = acc[gpvf_pkg::VarW+gpvf_pkg::FracBits-1:gpvf_pkg::FracBits];
      sat_val = 1'b0;
    end
  end

  // Control and history next state
  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    start_nxt     = start_r;
    res_hist_nxt  = res_hist_r;
    var_hist_nxt  = var_hist_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      pend_nxt = 1'b1;
    end

    if (sum_fire) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      for (int k = NA - 1; k > 0; k--) begin
        res_hist_nxt[k] = res_hist_r[k-1];
      end
      for (int k = NG - 1; k > 0; k--) begin
        var_hist_nxt[k] = var_hist_r[k-1];
      end
      res_hist_nxt[0] = resid_r;
      var_hist_nxt[0] = var_val;
      start_nxt       = last_r;
      // end of series: start over with empty history
      if (last_r) begin
        for (int k = 0; k < NA; k++) begin
          res_hist_nxt[k] = '0;
        end
        for (int k = 0; k < NG; k++) begin
          var_hist_nxt[k] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= 1'b1;
      for (int k = 0; k < NA; k++) begin
        res_hist_r[k] <= '0;
      end
      for (int k = 0; k < NG; k++) begin
        var_hist_r[k] <= '0;
      end
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      res_hist_r  <= res_hist_nxt;
      var_hist_r  <= var_hist_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      resid_r <= in_data.residual_sq;
      last_r  <= in_data.last_in_series;
      for (int k = 0; k < NA; k++) begin
        arch_prod_r[k] <= lag_product(res_hist_r[k], $signed(cfg.arch_coef[k]));
      end
      for (int k = 0; k < NG; k++) begin
        garch_prod_r[k] <= lag_product(var_hist_r[k], $signed(cfg.garch_coef[k]));
      end
    end
    if (sum_fire) begin
      out_data_r.variance  <= var_val;
      out_data_r.saturated <= sat_val;
      out_data_r.last_out  <= last_r;
    end
  end

endmodule

/* tb/tb_garch_pq_variance_filter_unit.sv */
`timescale 1ns / 1ps

module tb_garch_pq_variance_filter_unit;

  localparam int HoldCycles  = 300;   // long output hold-off
  localparam int DrainCycles = 8;     // settle time after the last result
  localparam int MaxReports  = 10;

  localparam int VarW     = gpvf_pkg::VarW;
  localparam int CoefW    = gpvf_pkg::CoefW;
  localparam int DataW    = gpvf_pkg::DataW;
  localparam int CoefRegs = gpvf_pkg::CoefRegs;
  localparam int FracBits = gpvf_pkg::FracBits;

  // Q16.32 and Q1.30 landmarks
  localparam logic [VarW-1:0]  QOne    = 48'h0001_0000_0000;
  localparam logic [VarW-1:0]  QHalf   = 48'h0000_8000_0000;
  localparam logic [VarW-1:0]  VarMax  = gpvf_pkg::VarMax;
  localparam logic [CoefW-1:0] CoefMin = 32'h8000_0000;
  localparam logic [CoefW-1:0] CoefMax = 32'h7FFF_FFFF;

  typedef enum int {CfgZero, CfgStable, CfgTop, CfgBottom, CfgWild} cfg_style_t;

  // DUT signals
  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  gpvf_pkg::in_item_t          in_data;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  gpvf_pkg::out_item_t         out_data;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [gpvf_pkg::AddrW-1:0]  paddr;
  logic [DataW-1:0]            pwdata;
  logic [DataW-1:0]            prdata;
  logic                        pready;

  // predictor: live register copy plus the filter history
  gpvf_pkg::cfg_t              live_cfg;
  logic [VarW-1:0]             past_resid [CoefRegs];
  logic [VarW-1:0]             past_var   [CoefRegs];
  logic                        new_series;

  gpvf_pkg::out_item_t         pending_variances [$];
  gpvf_pkg::out_item_t         chk_want;

  int                          errors;
  int                          n_samples;
  int                          n_results = 0;
  int                          n_settings;

  // traffic shaping knobs
  bit                          src_gaps;
  bit                          sink_stalls;
  int                          hold_req;
  int                          hold_done  = 0;
  int                          hold_left  = 0;
  int                          stall_left = 0;

  garch_pq_variance_filter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor. The full sum is kept exact in 128 bits: omega scaled by
  // 2^30 plus every lag product (units 2^-62), then rounded half up to
  // Q16.32 and clipped to 0 .. 2^48-1.
  // ---------------------------------------------------------------------
  task automatic predict_variance(input gpvf_pkg::in_item_t it);
    logic signed [127:0] acc;
    logic signed [127:0] rounded;
    gpvf_pkg::out_item_t res;
    res.last_out  = it.last_in_series;
    res.saturated = 1'b0;
    if (new_series) begin
      // series opens with the configured variance, never clipped
      res.variance = live_cfg.initial_variance;
    end else begin
      acc = $signed({80'd0, live_cfg.omega}) <<< FracBits;
      for (int k = 0; k < CoefRegs; k++) begin
        if (k < gpvf_pkg::ArchLagsDef)
          acc += $signed({80'd0, past_resid[k]}) *
                 $signed({{96{live_cfg.arch_coef[k][CoefW-1]}}, live_cfg.arch_coef[k]});
        if (k < gpvf_pkg::GarchLagsDef)
          acc += $signed({80'd0, past_var[k]}) *
                 $signed({{96{live_cfg.garch_coef[k][CoefW-1]}}, live_cfg.garch_coef[k]});
      end
      acc += 128'sd1 <<< (FracBits - 1);
      rounded = acc >>> FracBits;
      if (acc < 0) begin
        res.variance  = '0;
        res.saturated = 1'b1;
      end else if (rounded > $signed({80'd0, VarMax})) begin
        res.variance  = VarMax;
        res.saturated = 1'b1;
      end else begin
        res.variance = rounded[VarW-1:0];
      end
    end
    // shift history, newest at lag one
    for (int k = CoefRegs - 1; k > 0; k--) begin
      past_resid[k] = past_resid[k-1];
      past_var[k]   = past_var[k-1];
    end
    past_resid[0] = it.residual_sq;
    past_var[0]   = res.variance;
    if (it.last_in_series) begin
      // end of series wipes the history
      for (int k = 0; k < CoefRegs; k++) begin
        past_resid[k] = '0;
        past_var[k]   = '0;
      end
      new_series = 1'b1;
    end else begin
      new_series = 1'b0;
    end
    pending_variances.push_back(res);
  endtask

  // ---------------------------------------------------------------------
  // Input side: one sample per call, optional random gap in front.
  // Called at a rising edge; returns at the edge of the transfer.
  // ---------------------------------------------------------------------
  task automatic send_sample(input logic [VarW-1:0] resid, input logic last);
    gpvf_pkg::in_item_t it;
    it.residual_sq    = resid;
    it.last_in_series = last;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_variance(it);
    n_samples++;
  endtask

  // Drop valid and wait until every predicted variance has come back.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_variances.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // APB access: setup cycle, then access cycle; pready is tied high.
  // ---------------------------------------------------------------------
  task automatic write_reg(input gpvf_pkg::reg_idx_t idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      gpvf_pkg::RegOmega:   live_cfg.omega            = val[VarW-1:0];
      gpvf_pkg::RegInitVar: live_cfg.initial_variance = val[VarW-1:0];
      gpvf_pkg::RegArch1:   live_cfg.arch_coef[0]     = val[CoefW-1:0];
      gpvf_pkg::RegArch2:   live_cfg.arch_coef[1]     = val[CoefW-1:0];
      gpvf_pkg::RegArch3:   live_cfg.arch_coef[2]     = val[CoefW-1:0];
      gpvf_pkg::RegGarch1:  live_cfg.garch_coef[0]    = val[CoefW-1:0];
      gpvf_pkg::RegGarch2:  live_cfg.garch_coef[1]    = val[CoefW-1:0];
      gpvf_pkg::RegGarch3:  live_cfg.garch_coef[2]    = val[CoefW-1:0];
      default: ;
    endcase
  endtask

  // Read back one register; only the register's own width is compared.
  task automatic read_check(input gpvf_pkg::reg_idx_t idx);
    logic [DataW-1:0] got;
    logic [DataW-1:0] want;
    logic [DataW-1:0] mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    mask = {{(DataW-CoefW){1'b0}}, {CoefW{1'b1}}};
    case (idx)
      gpvf_pkg::RegOmega: begin
        want = DataW'(live_cfg.omega);
        mask = {{(DataW-VarW){1'b0}}, {VarW{1'b1}}};
      end
      gpvf_pkg::RegInitVar: begin
        want = DataW'(live_cfg.initial_variance);
        mask = {{(DataW-VarW){1'b0}}, {VarW{1'b1}}};
      end
      gpvf_pkg::RegArch1:  want = DataW'(live_cfg.arch_coef[0]);
      gpvf_pkg::RegArch2:  want = DataW'(live_cfg.arch_coef[1]);
      gpvf_pkg::RegArch3:  want = DataW'(live_cfg.arch_coef[2]);
      gpvf_pkg::RegGarch1: want = DataW'(live_cfg.garch_coef[0]);
      gpvf_pkg::RegGarch2: want = DataW'(live_cfg.garch_coef[1]);
      default:             want = DataW'(live_cfg.garch_coef[2]);
    endcase
    if ((got & mask) !== (want & mask))
      note_error($sformatf("readback reg %s: expected %h, got %h",
                           idx.name(), want & mask, got & mask));
  endtask

  // Write all eight registers (junk in unused upper bits), then read back.
  task automatic load_config(input gpvf_pkg::cfg_t c);
    write_reg(gpvf_pkg::RegOmega,   {16'($urandom), c.omega});
    write_reg(gpvf_pkg::RegInitVar, {16'($urandom), c.initial_variance});
    write_reg(gpvf_pkg::RegArch1,   {32'($urandom), c.arch_coef[0]});
    write_reg(gpvf_pkg::RegArch2,   {32'($urandom), c.arch_coef[1]});
    write_reg(gpvf_pkg::RegArch3,   {32'($urandom), c.arch_coef[2]});
    write_reg(gpvf_pkg::RegGarch1,  {32'($urandom), c.garch_coef[0]});
    write_reg(gpvf_pkg::RegGarch2,  {32'($urandom), c.garch_coef[1]});
    write_reg(gpvf_pkg::RegGarch3,  {32'($urandom), c.garch_coef[2]});
    for (int i = 0; i < 8; i++) read_check(gpvf_pkg::reg_idx_t'(i));
    n_settings++;
  endtask

  function automatic logic [VarW-1:0] rand_resid();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return VarMax;
      2, 3:    return VarW'({$urandom, $urandom});
      default: return VarW'($urandom) << $urandom_range(0, 4);  // around 0..16
    endcase
  endfunction

  function automatic gpvf_pkg::cfg_t pick_config(input cfg_style_t style);
    gpvf_pkg::cfg_t c;
    c.omega            = VarW'($urandom) << $urandom_range(0, 16);
    c.initial_variance = rand_resid();
    for (int k = 0; k < CoefRegs; k++) begin
      case (style)
        CfgZero: begin
          c.arch_coef[k]  = '0;
          c.garch_coef[k] = '0;
        end
        CfgStable: begin
          // roughly 0..0.1 ARCH and 0..0.3 GARCH per lag: mostly in range
          c.arch_coef[k]  = $urandom_range(0, 32'h0666_6666);
          c.garch_coef[k] = $urandom_range(0, 32'h1333_3333);
        end
        CfgTop: begin
          c.arch_coef[k]  = CoefMax;
          c.garch_coef[k] = CoefMax;
        end
        CfgBottom: begin
          c.arch_coef[k]  = CoefMin;
          c.garch_coef[k] = CoefMin;
        end
        default: begin
          c.arch_coef[k]  = $urandom;
          c.garch_coef[k] = $urandom;
        end
      endcase
    end
    if (style == CfgZero) begin
      c.omega            = '0;
      c.initial_variance = '0;
    end else if (style == CfgTop) begin
      c.omega            = VarMax;
      c.initial_variance = VarMax;
    end
    return c;
  endfunction

  // Series of random length with random residuals until n samples are in.
  task automatic run_series_traffic(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
      for (int i = 0; i < len && sent < n; i++) begin
        send_sample(rand_resid(), i == len - 1 || $urandom_range(0, 99) == 0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Output side: ready with random stall bursts, plus a long hold-off
  // requested by the test sequence and timed here.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: every transfer on the output is matched in order.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_variances.size() == 0) begin
        note_error($sformatf("result with nothing expected: var=%h sat=%b last=%b",
                             out_data.variance, out_data.saturated, out_data.last_out));
      end else begin
        chk_want = pending_variances.pop_front();
        if (out_data.variance !== chk_want.variance ||
            out_data.saturated !== chk_want.saturated ||
            out_data.last_out !== chk_want.last_out)
          note_error($sformatf(
            "result %0d: expected var=%h sat=%b last=%b, got var=%h sat=%b last=%b",
            n_results, chk_want.variance, chk_want.saturated, chk_want.last_out,
            out_data.variance, out_data.saturated, out_data.last_out));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Registers read zero after reset; the filter then gives zero variances.
  task automatic test_reset_state();
    for (int i = 0; i < 8; i++) read_check(gpvf_pkg::reg_idx_t'(i));
    send_sample(QOne, 1'b0);
    send_sample(VarMax, 1'b0);
    send_sample('0, 1'b1);
    drain_pipeline();
  endtask

  // Extremes, series boundaries, rounding and both clip directions.
  task automatic test_directed_cases();
    gpvf_pkg::cfg_t c;
    c.omega            = QOne;
    c.initial_variance = QHalf;
    c.arch_coef        = {32'h0147_AE14, 32'h0333_3333, 32'h0666_6666};
    c.garch_coef       = {32'h00A3_D70A, 32'h0333_3333, 32'h3333_3333};
    load_config(c);
    send_sample('0, 1'b0);        // opens series: initial variance
    send_sample(VarMax, 1'b0);
    send_sample('0, 1'b0);
    send_sample(QOne, 1'b0);
    send_sample(VarMax, 1'b1);    // last: history clears
    send_sample(QOne, 1'b1);      // single-sample series
    send_sample(QHalf, 1'b0);
    drain_pipeline();

    // rounding: weight 2^-30 on lag one, residual exactly half an lsb
    c = '0;
    c.arch_coef[0] = 32'd1;
    load_config(c);
    send_sample(48'h0000_2000_0000, 1'b0);
    send_sample(48'h0000_1FFF_FFFF, 1'b0);   // rounds half up to one lsb
    send_sample('0, 1'b0);                   // just below half: zero
    send_sample('0, 1'b1);
    drain_pipeline();

    // sum below zero clips to zero
    c = '0;
    c.arch_coef[0]  = CoefMin;
    c.garch_coef[2] = CoefMin;
    load_config(c);
    send_sample(VarMax, 1'b0);
    send_sample(48'd5, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b1);
    drain_pipeline();

    // sum above the maximum clips to the maximum
    c.omega            = VarMax;
    c.initial_variance = VarMax;
    c.arch_coef        = {CoefMax, CoefMax, CoefMax};
    c.garch_coef       = {CoefMax, CoefMax, CoefMax};
    load_config(c);
    send_sample(VarMax, 1'b0);
    send_sample(VarMax, 1'b0);
    send_sample(VarMax, 1'b0);
    send_sample(VarMax, 1'b1);
    drain_pipeline();
  endtask

  // Several register settings, each followed by random series traffic.
  task automatic test_random_settings();
    cfg_style_t style;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       style = CfgStable;
        1:       style = CfgTop;
        2:       style = CfgBottom;
        3:       style = CfgZero;
        4, 5:    style = CfgWild;
        default: style = CfgStable;
      endcase
      src_gaps    = (phase % 3 != 2);
      sink_stalls = (phase % 4 != 3);
      load_config(pick_config(style));
      run_series_traffic(200);
      drain_pipeline();
    end
  endtask

  // Output held off for a long stretch while input keeps coming: the
  // block must fill, drop in_ready and lose nothing.
  task automatic test_output_backpressure();
    src_gaps    = 1'b0;
    sink_stalls = 1'b1;
    load_config(pick_config(CfgStable));
    hold_req++;
    run_series_traffic(60);
    drain_pipeline();
  endtask

  // Sender pauses mid-series until all results are in, then resumes.
  task automatic test_sender_pause();
    src_gaps = 1'b1;
    for (int i = 0; i < 12; i++) send_sample(rand_resid(), 1'b0);
    drain_pipeline();
    for (int i = 0; i < 12; i++) send_sample(rand_resid(), i == 11);
    drain_pipeline();
  endtask

  // Full-rate stretch: no gaps, no stalls.
  task automatic test_full_rate();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    load_config(pick_config(CfgWild));
    run_series_traffic(150);
    drain_pipeline();
    load_config(pick_config(CfgStable));
    run_series_traffic(150);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    live_cfg    = '0;
    new_series  = 1'b1;
    for (int k = 0; k < CoefRegs; k++) begin
      past_resid[k] = '0;
      past_var[k]   = '0;
    end
    errors      = 0;
    n_samples   = 0;
    n_settings  = 0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    hold_req    = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_cases();
    test_random_settings();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();

    // bounded wait for the tail; anything left over is a failure
    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && pending_variances.size() != 0; i++) @(posedge clk);
    if (pending_variances.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_variances.size()));
    repeat (DrainCycles) @(posedge clk);

    $display("Run covered %0d samples and %0d results over %0d register settings,",
             n_samples, n_results, n_settings);
    $display("with random gaps, a long output hold-off and full-rate stretches.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d errors", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_variances.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
